FILE: rtl/sact_pkg.sv
// shared types, register indexes and constants for the sound activity capture trigger
`timescale 1ns / 1ps

package sact_pkg;

    // field widths
    localparam int SAMPLE_W    = 32;
    localparam int CAPT_W      = 16;
    localparam int THRESH_W    = 31;
    localparam int NEED_W      = 4;
    localparam int BLEN_W      = 13;
    localparam int BCNT_W      = 12;
    localparam int FLEN_W      = 16;
    localparam int HOLD_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int CAPT_SHIFT  = 14;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 3'd4;

    // reset values of the registers
    localparam logic [THRESH_W-1:0] RST_THRESHOLD = 31'd1800000;
    localparam logic [NEED_W-1:0]   RST_REQUIRED  = 4'd3;
    localparam logic [BLEN_W-1:0]   RST_BLOCK_LEN = 13'd512;
    localparam logic [FLEN_W-1:0]   RST_FRAME_LEN = 16'd16000;
    localparam logic [HOLD_W-1:0]   RST_HOLDOFF   = 16'd24000;

    // limits
    localparam logic [NEED_W-1:0] PERSIST_MAX = 4'd15;
    localparam logic [BLEN_W-1:0] BLOCK_MAX   = 13'd4096;

    // operating phase, one-hot
    typedef enum logic [2:0] {
        PH_DETECT  = 3'b001,
        PH_CAPTURE = 3'b010,
        PH_HOLD    = 3'b100
    } t_phase;

    // effective register values, already brought into range
    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [NEED_W-1:0]   need;
        logic [BLEN_W-1:0]   blen;
        logic [FLEN_W-1:0]   flen;
        logic [HOLD_W-1:0]   holdoff;
    } t_cfg;

    // one result from the core
    typedef struct packed {
        logic              emit;
        logic [CAPT_W-1:0] captured;
        logic              last;
    } t_result;

endpackage

FILE: rtl/sact_cfg_regs.sv
// configuration registers, brought into their working range as they are written
`timescale 1ns / 1ps

module sact_cfg_regs
    import sact_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [BLEN_W-1:0] wr_blen;
    logic [NEED_W-1:0] wr_need;
    logic [FLEN_W-1:0] wr_flen;

    // zero acts as one, block length saturates at its maximum
    always_comb begin
        wr_need = i_cfg_data[NEED_W-1:0];
        if (wr_need == '0) begin
            wr_need = NEED_W'(1);
        end
        wr_blen = i_cfg_data[BLEN_W-1:0];
        if (wr_blen == '0) begin
            wr_blen = BLEN_W'(1);
        end else if (wr_blen > BLOCK_MAX) begin
            wr_blen = BLOCK_MAX;
        end
        wr_flen = i_cfg_data[FLEN_W-1:0];
        if (wr_flen == '0) begin
            wr_flen = FLEN_W'(1);
        end
    end

    // register write decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: n_cfg.threshold = i_cfg_data[THRESH_W-1:0];
                CFG_REQUIRED:  n_cfg.need      = wr_need;
                CFG_BLOCK_LEN: n_cfg.blen      = wr_blen;
                CFG_FRAME_LEN: n_cfg.flen      = wr_flen;
                CFG_HOLDOFF:   n_cfg.holdoff   = i_cfg_data[HOLD_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.need      <= RST_REQUIRED;
            r_cfg.blen      <= RST_BLOCK_LEN;
            r_cfg.flen      <= RST_FRAME_LEN;
            r_cfg.holdoff   <= RST_HOLDOFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/sact_core.sv
// phase control, block peak tracking, persistence count and capture/holdoff counters
`timescale 1ns / 1ps

module sact_core
    import sact_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output t_result             o_res
);

    t_phase              r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_peak, n_peak;
    logic [BCNT_W-1:0]   r_bcnt, n_bcnt;
    logic [NEED_W-1:0]   r_pers, n_pers;
    logic [FLEN_W-1:0]   r_ccnt, n_ccnt;
    logic [HOLD_W-1:0]   r_hcnt, n_hcnt;

    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] thr_ext;
    logic                loud;
    logic [BLEN_W-1:0]   bcnt_inc;
    logic                block_end;
    logic [NEED_W-1:0]   pers_upd;
    logic [FLEN_W:0]     ccnt_inc;
    logic [HOLD_W:0]     hcnt_inc;
    logic                frame_done;
    logic                hold_done;

    // magnitude as unsigned, so the most negative sample gives 2^31
    assign mag     = i_sample[SAMPLE_W-1] ? (~i_sample + SAMPLE_W'(1)) : i_sample;
    assign thr_ext = {1'b0, i_cfg.threshold};
    // peak of the block including this sample is above threshold
    assign loud    = (mag > thr_ext) || (r_peak > thr_ext);

    assign bcnt_inc  = {1'b0, r_bcnt} + BLEN_W'(1);
    assign block_end = bcnt_inc >= i_cfg.blen;

    assign ccnt_inc   = {1'b0, r_ccnt} + (FLEN_W + 1)'(1);
    assign frame_done = ccnt_inc >= {1'b0, i_cfg.flen};
    assign hcnt_inc   = {1'b0, r_hcnt} + (HOLD_W + 1)'(1);
    assign hold_done  = hcnt_inc >= {1'b0, i_cfg.holdoff};

    // persistence rises on a loud block and decays otherwise
    always_comb begin
        if (loud) begin
            pers_upd = (r_pers == PERSIST_MAX) ? r_pers : r_pers + NEED_W'(1);
        end else begin
            pers_upd = (r_pers == '0) ? r_pers : r_pers - NEED_W'(1);
        end
    end

    // next state and result for one sample
    always_comb begin
        n_phase      = r_phase;
        n_peak       = r_peak;
        n_bcnt       = r_bcnt;
        n_pers       = r_pers;
        n_ccnt       = r_ccnt;
        n_hcnt       = r_hcnt;
        o_res.emit     = 1'b0;
        o_res.captured = i_sample[CAPT_SHIFT +: CAPT_W];
        o_res.last     = 1'b0;
        case (r_phase)
            PH_CAPTURE: begin
                o_res.emit = 1'b1;
                if (frame_done) begin
                    o_res.last = 1'b1;
                    n_ccnt     = '0;
                    n_hcnt     = '0;
                    if (i_cfg.holdoff == '0) begin
                        n_phase = PH_DETECT;
                        n_peak  = '0;
                        n_bcnt  = '0;
                        n_pers  = '0;
                    end else begin
                        n_phase = PH_HOLD;
                    end
                end else begin
                    n_ccnt = ccnt_inc[FLEN_W-1:0];
                end
            end
            PH_HOLD: begin
                if (hold_done) begin
                    n_hcnt  = '0;
                    n_phase = PH_DETECT;
                    n_peak  = '0;
                    n_bcnt  = '0;
                    n_pers  = '0;
                end else begin
                    n_hcnt = hcnt_inc[HOLD_W-1:0];
                end
            end
            default: begin
                // detecting, also any stray phase code
                n_phase = PH_DETECT;
                if (block_end) begin
                    n_peak = '0;
                    n_bcnt = '0;
                    if (pers_upd >= i_cfg.need) begin
                        n_pers  = '0;
                        n_ccnt  = '0;
                        n_phase = PH_CAPTURE;
                    end else begin
                        n_pers = pers_upd;
                    end
                end else begin
                    n_peak = (mag > r_peak) ? mag : r_peak;
                    n_bcnt = bcnt_inc[BCNT_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DETECT;
            r_peak  <= '0;
            r_bcnt  <= '0;
            r_pers  <= '0;
            r_ccnt  <= '0;
            r_hcnt  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_peak  <= n_peak;
            r_bcnt  <= n_bcnt;
            r_pers  <= n_pers;
            r_ccnt  <= n_ccnt;
            r_hcnt  <= n_hcnt;
        end
    end

endmodule

FILE: rtl/sound_activity_capture_trigger.sv
// top level: input register, detection core, configuration registers and result register
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------
//   sample   | in        | i_valid / o_stall    | i_sample[31:0]
//   result   | out       | o_valid / i_stall    | o_captured[15:0], o_last
//   config   | in        | i_cfg_we             | i_cfg_index[2:0], i_cfg_data
//
// one sample a cycle while o_stall is low; a result is registered after its sample transfer
// a sample passes one input register and one result register around the core
// o_stall rises only while the input register is full and a result waits under i_stall
// synchronous active-low reset clears state and restores register defaults
`timescale 1ns / 1ps

module sound_activity_capture_trigger
    import sact_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CAPT_W-1:0]     o_captured,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    logic [CAPT_W-1:0]   r_out_captured;
    logic                r_out_last;

    logic    out_load;
    logic    step;
    t_cfg    cfg;
    t_result res;

    // the result register can take a new value unless it holds a stalled one
    assign out_load = !(r_out_valid && i_stall);
    assign step     = r_in_valid && out_load;
    assign o_stall  = r_in_valid && !out_load;

    sact_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sact_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_sample <= i_sample;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= step && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_captured <= res.captured;
            r_out_last     <= res.last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_captured = r_out_captured;
    assign o_last     = r_out_last;

endmodule

FILE: rtl/sact_checker.sv
// port-level checks on the sound activity capture trigger, bound to the top level
`timescale 1ns / 1ps

module sact_checker
    import sact_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [SAMPLE_W-1:0]   i_sample,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [CAPT_W-1:0]     o_captured,
    input logic                  o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_captured) && $stable(o_last))
        else $error("stalled result changed");

    // a stalled sample holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_sample))
        else $error("stalled sample changed");

    // input back-pressure only comes from a result waiting under stall
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no waiting result");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // two frame ends never come back to back
    a_last_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !i_stall |=> !(o_valid && o_last))
        else $error("consecutive frame ends");

endmodule

bind sound_activity_capture_trigger sact_checker u_sact_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_sample   (i_sample),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_captured (o_captured),
    .o_last     (o_last)
);

FILE: tb/tb_sound_activity_capture_trigger.sv
// self-checking testbench for the sound activity capture trigger, with a built-in predictor
`timescale 1ns / 1ps

module tb_sound_activity_capture_trigger;
    import sact_pkg::*;

    // configuration indexes past the five registers
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [THRESH_W-1:0] THRESH_TOP = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [CAPT_W-1:0] captured;
        logic              last;
    } t_capture_beat;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [CAPT_W-1:0]     o_captured;
    logic                  o_last;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register copies as the block should hold them
    logic [THRESH_W-1:0] reg_threshold = RST_THRESHOLD;
    logic [NEED_W-1:0]   reg_required  = RST_REQUIRED;
    logic [BLEN_W-1:0]   reg_block_len = RST_BLOCK_LEN;
    logic [FLEN_W-1:0]   reg_frame_len = RST_FRAME_LEN;
    logic [HOLD_W-1:0]   reg_holdoff   = RST_HOLDOFF;

    // predicted trigger state
    t_phase              st_phase   = PH_DETECT;
    logic [SAMPLE_W-1:0] peak_mag   = '0;
    int unsigned         blk_count  = 0;
    int unsigned         persist    = 0;
    int unsigned         cap_count  = 0;
    int unsigned         hold_count = 0;

    t_capture_beat capture_q[$];
    int unsigned   fail_count   = 0;
    bit            tx_pauses    = 1'b1;
    bit            rx_pauses    = 1'b1;
    int unsigned   hold_request = 0;
    int unsigned   stall_left   = 0;

    sound_activity_capture_trigger uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_captured  (o_captured),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void flag_error(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns error: %s", $time, what);
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int unsigned pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // sample whose magnitude does not exceed lim
    function automatic logic [SAMPLE_W-1:0] quiet_sample(input logic [THRESH_W-1:0] lim);
        logic [SAMPLE_W-1:0] v;
        v = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // sample whose magnitude exceeds lim
    function automatic logic [SAMPLE_W-1:0] loud_sample(input logic [THRESH_W-1:0] lim);
        logic [SAMPLE_W-1:0] v;
        v = $urandom_range(32'h8000_0000, {1'b0, lim} + 32'd1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic void restart_detection();
        peak_mag  = '0;
        blk_count = 0;
        persist   = 0;
    endfunction

    // expected behaviour of the trigger for one accepted sample
    task automatic predict_capture(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] mag;
        int unsigned         blen;
        int unsigned         need;
        int unsigned         flen;
        t_capture_beat       beat;
        case (st_phase)
            PH_CAPTURE: begin
                flen = (reg_frame_len == 0) ? 1 : reg_frame_len;
                beat.captured = s[CAPT_SHIFT +: CAPT_W];
                beat.last     = (cap_count + 1 >= flen);
                capture_q.push_back(beat);
                if (beat.last) begin
                    cap_count  = 0;
                    hold_count = 0;
                    if (reg_holdoff == 0) begin
                        st_phase = PH_DETECT;
                        restart_detection();
                    end else begin
                        st_phase = PH_HOLD;
                    end
                end else begin
                    cap_count++;
                end
            end
            PH_HOLD: begin
                if (hold_count + 1 >= reg_holdoff) begin
                    hold_count = 0;
                    st_phase   = PH_DETECT;
                    restart_detection();
                end else begin
                    hold_count++;
                end
            end
            default: begin
                st_phase = PH_DETECT;
                mag  = s[SAMPLE_W-1] ? -s : s;
                blen = (reg_block_len == 0) ? 1 :
                       (reg_block_len > BLOCK_MAX) ? BLOCK_MAX : reg_block_len;
                need = (reg_required == 0) ? 1 : reg_required;
                if (mag > peak_mag) peak_mag = mag;
                // block end: update persistence, maybe start a capture
                if (blk_count + 1 >= blen) begin
                    if (peak_mag > reg_threshold) begin
                        if (persist < PERSIST_MAX) persist++;
                    end else if (persist > 0) begin
                        persist--;
                    end
                    peak_mag  = '0;
                    blk_count = 0;
                    if (persist >= need) begin
                        persist   = 0;
                        cap_count = 0;
                        st_phase  = PH_CAPTURE;
                    end
                end else begin
                    blk_count++;
                end
            end
        endcase
    endtask

    // one sample transfer, with an optional pause before it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = (tx_pauses && $urandom_range(0, 99) < 40) ? pause_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        predict_capture(s);
    endtask

    task automatic send_quiet(input int unsigned n, input logic [THRESH_W-1:0] lim);
        repeat (n) send_sample(quiet_sample(lim));
    endtask

    task automatic send_any(input int unsigned n);
        repeat (n) send_sample($urandom());
    endtask

    // stop offering, wait for every expected transfer, then let the pipeline settle
    task automatic wait_idle();
        int unsigned waited;
        i_valid <= 1'b0;
        waited = 0;
        while (capture_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (capture_q.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", capture_q.size()));
            capture_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: reg_threshold = data[THRESH_W-1:0];
            CFG_REQUIRED:  reg_required  = data[NEED_W-1:0];
            CFG_BLOCK_LEN: reg_block_len = data[BLEN_W-1:0];
            CFG_FRAME_LEN: reg_frame_len = data[FLEN_W-1:0];
            CFG_HOLDOFF:   reg_holdoff   = data[HOLD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [THRESH_W-1:0] thr, input int unsigned need,
                             input int unsigned blen, input int unsigned flen,
                             input int unsigned hold);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_REQUIRED, CFG_DATA_W'(need));
        write_reg(CFG_BLOCK_LEN, CFG_DATA_W'(blen));
        write_reg(CFG_FRAME_LEN, CFG_DATA_W'(flen));
        write_reg(CFG_HOLDOFF, CFG_DATA_W'(hold));
    endtask

    // reset values: one quiet block at exactly the threshold, three loud blocks,
    // then shorten the running capture and holdoff
    task automatic test_reset_defaults();
        logic [SAMPLE_W-1:0] thr32;
        thr32 = {1'b0, RST_THRESHOLD};
        send_quiet(RST_BLOCK_LEN - 1, RST_THRESHOLD);
        send_sample(-thr32);
        repeat (3) begin
            send_quiet(200, RST_THRESHOLD);
            send_sample(-(thr32 + 32'd1));
            send_quiet(RST_BLOCK_LEN - 201, RST_THRESHOLD);
        end
        send_any(4);
        wait_idle();
        write_reg(CFG_FRAME_LEN, CFG_DATA_W'(3));
        send_any(6);
        wait_idle();
        write_reg(CFG_HOLDOFF, CFG_DATA_W'(2));
        send_any(1);
        send_quiet(10, RST_THRESHOLD);
        wait_idle();
    endtask

    // zero lengths act as one, sample extremes, strict threshold at both ends
    task automatic test_field_extremes();
        logic [SAMPLE_W-1:0] pattern[16];
        pattern = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h0000_0001, 32'h3FFF_C000, 32'h0000_4000,
                    32'hC000_3FFF, 32'h0000_0000, 32'hFFFF_C000, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0000_0000, 32'h2000_0000};
        wait_idle();
        write_all('0, 0, 0, 0, 0);
        foreach (pattern[k]) send_sample(pattern[k]);
        wait_idle();
        write_reg(CFG_THRESHOLD, THRESH_TOP);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0001);
        send_sample(32'h8000_0000);
        send_sample(32'h1234_5678);
        wait_idle();
    endtask

    // unused indexes are ignored; block length above the maximum acts as the maximum
    task automatic test_block_len_max();
        wait_idle();
        for (int i = CFG_UNUSED_FIRST; i <= CFG_UNUSED_LAST; i++)
            write_reg(CFG_IDX_W'(i), {CFG_DATA_W{1'b1}});
        write_all(THRESH_TOP, 0, 8191, 0, 0);
        tx_pauses = 1'b0;
        send_sample(32'h8000_0000);
        send_quiet(BLOCK_MAX + 5, THRESH_TOP);
        tx_pauses = 1'b1;
        wait_idle();
    endtask

    // longest frame and holdoff, cut short by writes while they run
    task automatic test_extreme_lengths();
        wait_idle();
        write_all('0, 15, 1, 16'hFFFF, 16'hFFFF);
        repeat (14) send_sample(loud_sample('0));
        send_sample('0);
        repeat (2) send_sample(loud_sample('0));
        send_any(30);
        wait_idle();
        write_reg(CFG_FRAME_LEN, CFG_DATA_W'(10));
        send_any(21);
        wait_idle();
        write_reg(CFG_HOLDOFF, CFG_DATA_W'(5));
        send_any(1);
        repeat (3) send_sample(loud_sample('0));
        wait_idle();
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_output_pressure();
        wait_idle();
        write_all(31'd1000, 2, 3, 200, 3);
        repeat (6) send_sample(loud_sample(31'd1000));
        tx_pauses    = 1'b0;
        hold_request = 80;
        send_any(205);
        tx_pauses = 1'b1;
        wait_idle();
    endtask

    // random settings, mostly short blocks and frames, with loud bursts of varying density
    task automatic test_random_settings();
        logic [THRESH_W-1:0] thr;
        int unsigned         loud_pct;
        for (int round = 0; round < 10; round++) begin
            wait_idle();
            thr = $urandom_range(0, 1) ? THRESH_W'($urandom_range(0, 32'h7FFF_FFFF)) :
                                         THRESH_W'($urandom_range(0, 5000));
            write_all(thr,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 6),
                      $urandom_range(0, 10), $urandom_range(0, 8));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                          CFG_DATA_W'($urandom()));
            tx_pauses = (round % 3 != 0);
            rx_pauses = (round % 4 != 1);
            case (round % 4)
                0: loud_pct = 10;
                1: loud_pct = 50;
                2: loud_pct = 80;
                default: loud_pct = 95;
            endcase
            repeat (50) begin
                if ($urandom_range(0, 99) < loud_pct) send_sample(loud_sample(thr));
                else send_sample(quiet_sample(thr));
            end
        end
        tx_pauses = 1'b1;
        rx_pauses = 1'b1;
    endtask

    // receiver: random stalls, plus a long hold when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (rx_pauses && $urandom_range(0, 99) < 20) stall_left = pause_len();
            end
        end
    end

    // compare each result transfer with the oldest expected one
    initial begin
        t_capture_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (capture_q.size() == 0) begin
                    flag_error($sformatf("unexpected result captured=%h last=%b",
                                         o_captured, o_last));
                end else begin
                    want = capture_q.pop_front();
                    if (o_captured !== want.captured || o_last !== want.last)
                        flag_error($sformatf("captured exp %h got %h, last exp %b got %b",
                                             want.captured, o_captured, want.last, o_last));
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_block_len_max();
        test_extreme_lengths();
        test_output_pressure();
        test_random_settings();
        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
